// File: hw/rtl/dwc_pkg.sv
// Shared types and constants of the depthwise 3x3 int8 convolution unit.
// No dependencies.
`default_nettype none

package dwc_pkg;

    localparam int KERNEL_TAPS = 9;
    localparam logic [3:0] TAP_LAST = 4'(KERNEL_TAPS - 1);

    // request codes
    localparam logic [1:0] REQ_PIXEL  = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_BIAS   = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_CHANNELS     = 3'd2;
    localparam logic [2:0] CFG_IN_ZP        = 3'd3;
    localparam logic [2:0] CFG_WEIGHT_ZP    = 3'd4;
    localparam logic [2:0] CFG_MULTIPLIER   = 3'd5;
    localparam logic [2:0] CFG_SHIFT        = 3'd6;
    localparam logic [2:0] CFG_OUT_ZP       = 3'd7;

    localparam logic signed [63:0] SAT_MIN = -64'sd128;
    localparam logic signed [63:0] SAT_MAX = 64'sd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_TAPS,
        ST_ACC,
        ST_MUL,
        ST_SHIFT,
        ST_SAT,
        ST_OUT
    } dwc_state_t;

    // datapath controls
    typedef struct packed {
        logic mac_step;
        logic mac_first;
        logic tap_ok;
        logic mul_en;
        logic shift_en;
        logic sat_en;
    } dwc_ctl_t;

    function automatic logic [1:0] mod3(input logic [2:0] v);
        logic [1:0] r;
        unique case (v)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dwc_if.sv
// Request and result channel interfaces of the depthwise convolution unit.
// No dependencies.
`default_nettype none

interface dwc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [5:0]         channel_index;
    logic [3:0]         tap_index;
    logic signed [7:0]  byte_value;
    logic signed [31:0] bias_value;

    modport source (output valid, req_type, channel_index, tap_index, byte_value,
                    bias_value, input ready);
    modport sink (input valid, req_type, channel_index, tap_index, byte_value,
                  bias_value, output ready);
endinterface

interface dwc_res_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_value;
    logic [15:0]       out_row;
    logic [7:0]        out_col;
    logic [5:0]        out_channel;
    logic              last_of_run;

    modport source (output valid, out_value, out_row, out_col, out_channel, last_of_run,
                    input ready);
    modport sink (input valid, out_value, out_row, out_col, out_channel, last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dwc_store.sv
// Line, weight and bias memories, registered reads.
// Depends on nothing but its parameters.
`default_nettype none

module dwc_store #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_CHANNELS = 64,
    localparam int LAW = $clog2(3 * MAX_WIDTH * MAX_CHANNELS),
    localparam int WAW = $clog2(9 * MAX_CHANNELS),
    localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire logic             clk,
    input  wire logic             line_we,
    input  wire logic [LAW-1:0]   line_waddr,
    input  wire logic [7:0]       line_wdata,
    input  wire logic [LAW-1:0]   line_raddr,
    output logic [7:0]            line_q,
    input  wire logic             weight_we,
    input  wire logic [WAW-1:0]   weight_waddr,
    input  wire logic [7:0]       weight_wdata,
    input  wire logic [WAW-1:0]   weight_raddr,
    output logic [7:0]            weight_q,
    input  wire logic             bias_we,
    input  wire logic [BAW-1:0]   bias_waddr,
    input  wire logic [31:0]      bias_wdata,
    input  wire logic [BAW-1:0]   bias_raddr,
    output logic [31:0]           bias_q
);

    logic [7:0]  line_mem   [3 * MAX_WIDTH * MAX_CHANNELS];
    logic [7:0]  weight_mem [9 * MAX_CHANNELS];
    logic [31:0] bias_mem   [MAX_CHANNELS];

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        line_q <= line_mem[line_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[weight_waddr] <= weight_wdata;
        end
        weight_q <= weight_mem[weight_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bias_we)
        begin
            bias_mem[bias_waddr] <= bias_wdata;
        end
        bias_q <= bias_mem[bias_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/dwc_datapath.sv
// Multiply-accumulate over the taps and the requantization pipeline.
// Depends on dwc_pkg.
`default_nettype none

module dwc_datapath
    import dwc_pkg::*;
(
    input  wire logic              clk,
    input  wire dwc_ctl_t          ctl,
    input  wire logic [7:0]        line_q,
    input  wire logic [7:0]        weight_q,
    input  wire logic [31:0]       bias_q,
    input  wire logic [7:0]        in_zp,
    input  wire logic [7:0]        weight_zp,
    input  wire logic [31:0]       multiplier,
    input  wire logic [5:0]        shift,
    input  wire logic [7:0]        out_zp,
    output logic signed [7:0]      out_value
);

    logic signed [8:0]  s_diff;
    logic signed [8:0]  w_diff;
    logic signed [17:0] term;
    logic [31:0]        acc_next;
    logic [31:0]        acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted_reg;
    logic signed [63:0] biased;
    logic signed [7:0]  out_value_reg;

    always_comb
    begin
        s_diff   = $signed({line_q[7], line_q}) - $signed({in_zp[7], in_zp});
        w_diff   = $signed({weight_q[7], weight_q}) - $signed({weight_zp[7], weight_zp});
        term     = s_diff * w_diff;
        acc_next = (ctl.mac_first ? bias_q : acc_reg)
                 + (ctl.tap_ok ? {{14{term[17]}}, term} : 32'd0);
        biased   = shifted_reg + {{56{out_zp[7]}}, out_zp};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_step)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= $signed(acc_reg) * $signed(multiplier);
        end
        if (ctl.shift_en)
        begin
            shifted_reg <= prod_reg >>> shift;
        end
        if (ctl.sat_en)
        begin
            if (biased < SAT_MIN)
            begin
                out_value_reg <= SAT_MIN[7:0];
            end
            else if (biased > SAT_MAX)
            begin
                out_value_reg <= SAT_MAX[7:0];
            end
            else
            begin
                out_value_reg <= biased[7:0];
            end
        end
    end

    assign out_value = out_value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/depthwise_conv3x3_int8_unit.sv
// Top level of the streaming int8 depthwise 3x3 convolution unit.
// Depends on dwc_pkg, dwc_if, dwc_store and dwc_datapath.
`default_nettype none

// Streaming depthwise 3x3 convolution, stride 1, zero-contribution borders. Load
// weights (req_type 1) and biases (req_type 2) first, then send one frame of int8
// samples in row, column, channel order. Each sample transfer may complete up to four
// outputs, delivered in order with last_of_run on the final one. Items are handled one
// at a time, and no new request is taken until all outputs of a sample are delivered;
// each output is selected, has its nine taps read through one memory port into one
// multiply-accumulate, waits for the read of the last tap, passes three requantizer
// stages and is then offered until taken, so any output stall holds it. Line,
// weight and bias memories start undefined; no clearing pass runs. Any configuration
// write restarts the frame at row 0, column 0, channel 0.
module depthwise_conv3x3_int8_unit
    import dwc_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dwc_req_if.sink          samples,
    dwc_res_if.source        results,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int LAW = $clog2(3 * MAX_WIDTH * MAX_CHANNELS);
    localparam int WAW = $clog2(9 * MAX_CHANNELS);
    localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ROW_STRIDE = MAX_WIDTH * MAX_CHANNELS;

    // configuration registers
    logic [15:0] height_reg;
    logic [8:0]  width_reg;
    logic [6:0]  chans_reg;
    logic [7:0]  in_zp_reg;
    logic [7:0]  weight_zp_reg;
    logic [31:0] mult_reg;
    logic [5:0]  shift_reg;
    logic [7:0]  out_zp_reg;

    // effective geometry, stored as last index
    logic [15:0]    h_m1;
    logic [XW-1:0]  w_m1;
    logic [CHW-1:0] cc_m1;

    // frame position of the next sample
    logic [15:0]    row_reg, row_next;
    logic [1:0]     rm_reg, rm_next;
    logic [XW-1:0]  col_reg, col_next;
    logic [CHW-1:0] chan_reg, chan_next;

    // sample under work
    logic [15:0]    cur_r_reg;
    logic [1:0]     cur_rm_reg;
    logic [XW-1:0]  cur_x_reg;
    logic [CHW-1:0] cur_c_reg;
    logic [3:0]     mask_reg;

    // output under work
    logic [3:0]     pick_reg;
    logic           orow_reg;
    logic [15:0]    oy_reg;
    logic [XW-1:0]  ox_reg;
    logic           last_reg;

    // tap sequencer
    logic [3:0]     tap_reg;
    logic [1:0]     ky_reg;
    logic [1:0]     kx_reg;
    logic           iss_vld_reg;
    logic           iss_first_reg;
    logic           iss_ok_reg;

    dwc_state_t state_reg, state_next;

    logic           req_xfer;
    logic           pix_xfer;
    logic           res_xfer;
    logic [3:0]     emit_mask;
    logic [3:0]     pick_oh;
    logic           tap_ok;
    logic [1:0]     slot;
    logic [31:0]    ix_full;
    logic [31:0]    line_raddr_full;
    logic [31:0]    line_waddr_full;
    logic [31:0]    w_tmp;
    logic [31:0]    c_tmp;
    logic           ch_ok;

    logic           line_we;
    logic [LAW-1:0] line_waddr;
    logic [LAW-1:0] line_raddr;
    logic [7:0]     line_q;
    logic           weight_we;
    logic [WAW-1:0] weight_waddr;
    logic [WAW-1:0] weight_raddr;
    logic [7:0]     weight_q;
    logic           bias_we;
    logic [31:0]    bias_q;
    dwc_ctl_t       ctl;
    logic signed [7:0] dp_value;

    assign req_xfer = samples.valid && samples.ready;
    assign pix_xfer = req_xfer && (samples.req_type == REQ_PIXEL);
    assign res_xfer = results.valid && results.ready;

    // geometry clamps
    always_comb
    begin
        if (width_reg == 9'd0)
        begin
            w_tmp = 32'd0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_tmp = 32'(MAX_WIDTH - 1);
        end
        else
        begin
            w_tmp = 32'(width_reg) - 32'd1;
        end
        if (chans_reg == 7'd0)
        begin
            c_tmp = 32'd0;
        end
        else if (32'(chans_reg) > 32'(MAX_CHANNELS))
        begin
            c_tmp = 32'(MAX_CHANNELS - 1);
        end
        else
        begin
            c_tmp = 32'(chans_reg) - 32'd1;
        end
        h_m1  = (height_reg == 16'd0) ? 16'd0 : height_reg - 16'd1;
        w_m1  = XW'(w_tmp);
        cc_m1 = CHW'(c_tmp);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= 16'd1;
            width_reg     <= 9'd1;
            chans_reg     <= 7'd1;
            in_zp_reg     <= 8'd0;
            weight_zp_reg <= 8'd0;
            mult_reg      <= 32'd1;
            shift_reg     <= 6'd0;
            out_zp_reg    <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_HEIGHT: height_reg    <= cfg_data[15:0];
                CFG_FRAME_WIDTH:  width_reg     <= cfg_data[8:0];
                CFG_CHANNELS:     chans_reg     <= cfg_data[6:0];
                CFG_IN_ZP:        in_zp_reg     <= cfg_data[7:0];
                CFG_WEIGHT_ZP:    weight_zp_reg <= cfg_data[7:0];
                CFG_MULTIPLIER:   mult_reg      <= cfg_data;
                CFG_SHIFT:        shift_reg     <= cfg_data[5:0];
                CFG_OUT_ZP:       out_zp_reg    <= cfg_data[7:0];
                default:          height_reg    <= height_reg;
            endcase
        end
    end

    // raster position advance; any config write restarts the frame
    always_comb
    begin
        row_next  = row_reg;
        rm_next   = rm_reg;
        col_next  = col_reg;
        chan_next = chan_reg;
        if (cfg_wr_en)
        begin
            row_next  = 16'd0;
            rm_next   = 2'd0;
            col_next  = '0;
            chan_next = '0;
        end
        else if (pix_xfer)
        begin
            if (chan_reg == cc_m1)
            begin
                chan_next = '0;
                if (col_reg == w_m1)
                begin
                    col_next = '0;
                    if (row_reg == h_m1)
                    begin
                        row_next = 16'd0;
                        rm_next  = 2'd0;
                    end
                    else
                    begin
                        row_next = row_reg + 16'd1;
                        rm_next  = (rm_reg == 2'd2) ? 2'd0 : rm_reg + 2'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + XW'(1);
                end
            end
            else
            begin
                chan_next = chan_reg + CHW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 16'd0;
            rm_reg   <= 2'd0;
            col_reg  <= '0;
            chan_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            rm_reg   <= rm_next;
            col_reg  <= col_next;
            chan_reg <= chan_next;
        end
    end

    // outputs completed by this sample, in delivery order:
    // bit 0 (r-1,x-1), bit 1 (r-1,x), bit 2 (r,x-1), bit 3 (r,x)
    always_comb
    begin
        emit_mask[0] = (row_reg != 16'd0) && (col_reg != '0);
        emit_mask[1] = (row_reg != 16'd0) && (col_reg == w_m1);
        emit_mask[2] = (row_reg == h_m1) && (col_reg != '0);
        emit_mask[3] = (row_reg == h_m1) && (col_reg == w_m1);
        pick_oh      = mask_reg & (~mask_reg + 4'd1);
    end

    // tap addressing: row oy+ky-1 = r-2+orow+ky, so its slot is (rm+1+orow+ky) mod 3
    always_comb
    begin
        slot    = mod3(3'(cur_rm_reg) + 3'd1 + 3'(orow_reg) + 3'(ky_reg));
        ix_full = 32'(ox_reg) + 32'(kx_reg) - 32'd1;
        tap_ok  = !(((ky_reg == 2'd0) && (oy_reg == 16'd0))
                 || ((ky_reg == 2'd2) && (oy_reg == h_m1))
                 || ((kx_reg == 2'd0) && (ox_reg == '0))
                 || ((kx_reg == 2'd2) && (ox_reg == w_m1)));
        line_raddr_full = 32'(slot) * ROW_STRIDE + ix_full * MAX_CHANNELS
                        + 32'(cur_c_reg);
        line_waddr_full = 32'(rm_reg) * ROW_STRIDE + 32'(col_reg) * MAX_CHANNELS
                        + 32'(chan_reg);
        ch_ok = 32'(samples.channel_index) < 32'(MAX_CHANNELS);
    end

    assign line_we      = pix_xfer;
    assign line_waddr   = LAW'(line_waddr_full);
    assign line_raddr   = LAW'(line_raddr_full);
    assign weight_we    = req_xfer && (samples.req_type == REQ_WEIGHT)
                        && (samples.tap_index <= TAP_LAST) && ch_ok;
    assign weight_waddr = WAW'(32'(samples.tap_index) * MAX_CHANNELS
                        + 32'(samples.channel_index));
    assign weight_raddr = WAW'(32'(tap_reg) * MAX_CHANNELS + 32'(cur_c_reg));
    assign bias_we      = req_xfer && (samples.req_type == REQ_BIAS) && ch_ok;

    dwc_store #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .clk          (clk),
        .line_we      (line_we),
        .line_waddr   (line_waddr),
        .line_wdata   (samples.byte_value),
        .line_raddr   (line_raddr),
        .line_q       (line_q),
        .weight_we    (weight_we),
        .weight_waddr (weight_waddr),
        .weight_wdata (samples.byte_value),
        .weight_raddr (weight_raddr),
        .weight_q     (weight_q),
        .bias_we      (bias_we),
        .bias_waddr   (BAW'(samples.channel_index)),
        .bias_wdata   (samples.bias_value),
        .bias_raddr   (BAW'(cur_c_reg)),
        .bias_q       (bias_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (pix_xfer) state_next = ST_PICK;
            ST_PICK:  state_next = (mask_reg == 4'd0) ? ST_IDLE : ST_TAPS;
            ST_TAPS:  if (tap_reg == TAP_LAST) state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_SAT;
            ST_SAT:   state_next = ST_OUT;
            ST_OUT:   if (results.ready) state_next = ST_PICK;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        samples.ready = (state_reg == ST_IDLE);
        results.valid = (state_reg == ST_OUT);
        ctl.mac_step  = iss_vld_reg;
        ctl.mac_first = iss_first_reg;
        ctl.tap_ok    = iss_ok_reg;
        ctl.mul_en    = (state_reg == ST_MUL);
        ctl.shift_en  = (state_reg == ST_SHIFT);
        ctl.sat_en    = (state_reg == ST_SAT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= 4'd0;
            iss_vld_reg   <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_vld_reg   <= (state_reg == ST_TAPS);
            iss_first_reg <= (state_reg == ST_TAPS) && (tap_reg == 4'd0);
            iss_ok_reg    <= tap_ok;
            if (pix_xfer)
            begin
                mask_reg <= emit_mask;
            end
            else if (res_xfer)
            begin
                mask_reg <= mask_reg & ~pick_reg;
            end
        end
    end

    // payload side registers
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            cur_r_reg  <= row_reg;
            cur_rm_reg <= rm_reg;
            cur_x_reg  <= col_reg;
            cur_c_reg  <= chan_reg;
        end
        if (state_reg == ST_PICK)
        begin
            pick_reg <= pick_oh;
            orow_reg <= pick_oh[2] | pick_oh[3];
            oy_reg   <= (pick_oh[2] | pick_oh[3]) ? cur_r_reg : cur_r_reg - 16'd1;
            ox_reg   <= (pick_oh[0] | pick_oh[2]) ? cur_x_reg - XW'(1) : cur_x_reg;
            last_reg <= ((mask_reg & ~pick_oh) == 4'd0);
            tap_reg  <= 4'd0;
            ky_reg   <= 2'd0;
            kx_reg   <= 2'd0;
        end
        else if (state_reg == ST_TAPS)
        begin
            tap_reg <= tap_reg + 4'd1;
            if (kx_reg == 2'd2)
            begin
                kx_reg <= 2'd0;
                ky_reg <= ky_reg + 2'd1;
            end
            else
            begin
                kx_reg <= kx_reg + 2'd1;
            end
        end
    end

    dwc_datapath u_datapath (
        .clk        (clk),
        .ctl        (ctl),
        .line_q     (line_q),
        .weight_q   (weight_q),
        .bias_q     (bias_q),
        .in_zp      (in_zp_reg),
        .weight_zp  (weight_zp_reg),
        .multiplier (mult_reg),
        .shift      (shift_reg),
        .out_zp     (out_zp_reg),
        .out_value  (dp_value)
    );

    assign results.out_value   = dp_value;
    assign results.out_row     = oy_reg;
    assign results.out_col     = 8'(ox_reg);
    assign results.out_channel = 6'(cur_c_reg);
    assign results.last_of_run = last_reg;

    // one item at a time: no request transfer while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.ready && results.valid))
        else $error("request accepted while a result is pending");

    // a sample transfer always goes to output selection next
    a_pix_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> (state_reg == ST_PICK))
        else $error("sample transfer did not start output selection");

    // the last result of a run leaves no other output pending
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_of_run) |-> $onehot(mask_reg))
        else $error("last_of_run with outputs still pending");

    // tap issue only while the tap sequencer runs
    a_mac_window: assert property (@(posedge clk) disable iff (!rst_n)
        iss_vld_reg |-> ($past(state_reg) == ST_TAPS))
        else $error("accumulate step outside tap sequence");

endmodule

`default_nettype wire
